// ----- src/cfc_pkg.sv -----
// cfc_pkg: shared types and constants of the character frequency counter
// depends on nothing; imported by cfc_front, cfc_back and the top level
`default_nettype none

package cfc_pkg;

   localparam int SYMBOL_BITS = 7;
   localparam int OCC_BITS    = 16;

   localparam logic [SYMBOL_BITS-1:0] QUOTE_CODE = 7'd34;

   typedef enum logic {
      CMD_COUNT = 1'b0,
      CMD_FETCH = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [SYMBOL_BITS-1:0] symbol;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

`default_nettype wire

// ----- src/cfc_front.sv -----
// cfc_front: accepts transactions, drops ignored symbols, two-entry command queue
// depends on cfc_pkg; feeds cfc_back
`default_nettype none

module cfc_front
   import cfc_pkg::*;
#(
   parameter int ALPHABET_SIZE = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_op,
   input  wire logic [SYMBOL_BITS-1:0] req_symbol,
   output head_type                    head,
   input  wire logic                   pop
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       drop;
   logic       push;
   item_type   new_item;

   always_comb begin
      drop = (req_op == CMD_COUNT) &&
             ((req_symbol == '0) || (req_symbol == QUOTE_CODE) ||
              (9'(req_symbol) >= 9'(ALPHABET_SIZE)));
      busy = (count_ff == 2'd2);
      push = start && !busy && !drop;
      new_item.cmd    = cmd_type'(req_op);
      new_item.symbol = req_symbol;
      head.valid = (count_ff != 2'd0);
      head.item  = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != 2'd0))
      else $error("queue popped while empty");

endmodule

`default_nettype wire

// ----- src/cfc_back.sv -----
// cfc_back: count store, nonzero map, fetch scan and result registers
// depends on cfc_pkg; takes commands from cfc_front
`default_nettype none

module cfc_back
   import cfc_pkg::*;
#(
   parameter int ALPHABET_SIZE = 128,
   parameter int COUNT_BITS    = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire head_type               head,
   output logic                        pop,
   output logic                        rsp_strobe,
   output logic                        rsp_found,
   output logic [SYMBOL_BITS-1:0]      rsp_char_code,
   output logic [OCC_BITS-1:0]         rsp_occurrences,
   output logic                        rsp_last_entry
);

   localparam int IDX_BITS = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int PTR_BITS = $clog2(ALPHABET_SIZE + 1);
   localparam logic [PTR_BITS-1:0] PTR_END = PTR_BITS'(ALPHABET_SIZE);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CNT_WR,
      ST_FIND,
      ST_MORE
   } state_type;

   logic [COUNT_BITS-1:0]    mem [ALPHABET_SIZE];
   logic [COUNT_BITS-1:0]    rd_data_ff;

   state_type                state_ff;
   logic [ALPHABET_SIZE-1:0] valid_ff;
   logic [IDX_BITS-1:0]      cursor_ff;
   logic [PTR_BITS-1:0]      ptr_ff;
   logic [IDX_BITS-1:0]      hit_ff;
   logic [IDX_BITS-1:0]      cnt_addr_ff;
   logic                     rsp_strobe_ff;
   logic                     rsp_found_ff;
   logic [SYMBOL_BITS-1:0]   rsp_char_code_ff;
   logic [OCC_BITS-1:0]      rsp_occ_ff;
   logic                     rsp_last_ff;

   logic [IDX_BITS-1:0]      ptr_idx;
   logic                     rd_en;
   logic [IDX_BITS-1:0]      rd_addr;
   logic                     we;
   logic [COUNT_BITS-1:0]    base;
   logic [COUNT_BITS-1:0]    wr_data;

   always_comb begin
      ptr_idx = ptr_ff[IDX_BITS-1:0];
      pop     = (state_ff == ST_IDLE) && head.valid;
      rd_en   = 1'b0;
      rd_addr = ptr_idx;
      if (pop && (head.item.cmd == CMD_COUNT)) begin
         rd_en   = 1'b1;
         rd_addr = IDX_BITS'(head.item.symbol);
      end else if ((state_ff == ST_FIND) && (ptr_ff != PTR_END) && valid_ff[ptr_idx]) begin
         rd_en = 1'b1;
      end
      we      = (state_ff == ST_CNT_WR);
      base    = valid_ff[cnt_addr_ff] ? rd_data_ff : '0;
      wr_data = (base == '1) ? base : base + COUNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[cnt_addr_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         cursor_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (head.item.cmd == CMD_COUNT) begin
                     cnt_addr_ff <= IDX_BITS'(head.item.symbol);
                     state_ff    <= ST_CNT_WR;
                  end else begin
                     ptr_ff   <= PTR_BITS'(cursor_ff);
                     state_ff <= ST_FIND;
                  end
               end
            end
            ST_CNT_WR: begin
               valid_ff[cnt_addr_ff] <= 1'b1;
               state_ff              <= ST_IDLE;
            end
            ST_FIND: begin
               if (ptr_ff == PTR_END) begin
                  rsp_strobe_ff    <= 1'b1;
                  rsp_found_ff     <= 1'b0;
                  rsp_char_code_ff <= '0;
                  rsp_occ_ff       <= '0;
                  rsp_last_ff      <= 1'b0;
                  cursor_ff        <= '0;
                  state_ff         <= ST_IDLE;
               end else begin
                  if (valid_ff[ptr_idx]) begin
                     hit_ff   <= ptr_idx;
                     state_ff <= ST_MORE;
                  end
                  ptr_ff <= ptr_ff + PTR_BITS'(1);
               end
            end
            ST_MORE: begin
               if (ptr_ff == PTR_END) begin
                  rsp_strobe_ff    <= 1'b1;
                  rsp_found_ff     <= 1'b1;
                  rsp_char_code_ff <= SYMBOL_BITS'(hit_ff);
                  rsp_occ_ff       <= OCC_BITS'(rd_data_ff);
                  rsp_last_ff      <= 1'b1;
                  valid_ff         <= '0;
                  cursor_ff        <= '0;
                  state_ff         <= ST_IDLE;
               end else if (valid_ff[ptr_idx]) begin
                  rsp_strobe_ff    <= 1'b1;
                  rsp_found_ff     <= 1'b1;
                  rsp_char_code_ff <= SYMBOL_BITS'(hit_ff);
                  rsp_occ_ff       <= OCC_BITS'(rd_data_ff);
                  rsp_last_ff      <= 1'b0;
                  cursor_ff        <= IDX_BITS'(hit_ff + IDX_BITS'(1));
                  state_ff         <= ST_IDLE;
               end else begin
                  ptr_ff <= ptr_ff + PTR_BITS'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_char_code   = rsp_char_code_ff;
   assign rsp_occurrences = rsp_occ_ff;
   assign rsp_last_entry  = rsp_last_ff;

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_found_ff) |->
         ((rsp_occ_ff == '0) && (rsp_char_code_ff == '0) && !rsp_last_ff))
      else $error("empty result carries nonzero fields");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_last_ff) |-> ((valid_ff == '0) && (cursor_ff == '0)))
      else $error("store not cleared after last entry");

   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MORE) |-> valid_ff[hit_ff])
      else $error("scan hit on an empty entry");

endmodule

`default_nettype wire

// ----- src/character_frequency_count_top.sv -----
// character_frequency_count_top: character histogram with ascending fetch
// depends on cfc_pkg, cfc_front and cfc_back
//
//  channel  ports                                           handshake
//  request  req_op, req_symbol                              start high, busy low
//  result   rsp_found, rsp_char_code, rsp_occurrences,      rsp_strobe, one cycle
//           rsp_last_entry
//
// a count holds the back end for a store read and then a store write
// a fetch holds it while the scan looks at one entry a cycle from the cursor upward
// ignored symbols are dropped at acceptance and take no back-end time
// busy rises when the two-entry queue is full; results cannot be stalled
// reset clears the nonzero map and cursor at once, so no clearing pass is needed
`default_nettype none

module character_frequency_count_top
   import cfc_pkg::*;
#(
   parameter int ALPHABET_SIZE = 128,
   parameter int COUNT_BITS    = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_op,
   input  wire logic [SYMBOL_BITS-1:0] req_symbol,
   output logic                        rsp_strobe,
   output logic                        rsp_found,
   output logic [SYMBOL_BITS-1:0]      rsp_char_code,
   output logic [OCC_BITS-1:0]         rsp_occurrences,
   output logic                        rsp_last_entry
);

   head_type head;
   logic     pop;

   cfc_front #(
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_op     (req_op),
      .req_symbol (req_symbol),
      .head       (head),
      .pop        (pop)
   );

   cfc_back #(
      .ALPHABET_SIZE(ALPHABET_SIZE),
      .COUNT_BITS   (COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_found       (rsp_found),
      .rsp_char_code   (rsp_char_code),
      .rsp_occurrences (rsp_occurrences),
      .rsp_last_entry  (rsp_last_entry)
   );

endmodule

`default_nettype wire

// ----- tb/sv/character_frequency_count_top_tb.sv -----
// character_frequency_count_top_tb: self-checking bench for the character histogram
// drives count and fetch transactions, predicts every listing entry, checks each strobe
// depends on cfc_pkg and character_frequency_count_top
`timescale 1ns / 100ps

module character_frequency_count_top_tb
   import cfc_pkg::*;
();

   localparam int ALPHABET     = 128;
   localparam int TALLY_MAX    = 65535;
   localparam int RANDOM_ITEMS = 1200;
   localparam int SCRIPT_ROWS  = 26;
   localparam int CYCLE_LIMIT  = 3000000;

   typedef struct packed {
      logic                   found;
      logic [SYMBOL_BITS-1:0] code;
      logic [OCC_BITS-1:0]    occ;
      logic                   last;
   } listing_entry_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [SYMBOL_BITS-1:0] sym;
      logic                   typed;
      listing_entry_type      want;
   } script_row_type;

   localparam listing_entry_type NO_ENTRY = '0;

   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{CMD_FETCH, 7'd0,       1'b1, NO_ENTRY},
      '{CMD_COUNT, 7'd0,       1'b0, NO_ENTRY},
      '{CMD_COUNT, QUOTE_CODE, 1'b0, NO_ENTRY},
      '{CMD_FETCH, 7'd127,     1'b1, NO_ENTRY},
      '{CMD_COUNT, 7'd1,       1'b0, NO_ENTRY},
      '{CMD_COUNT, 7'd127,     1'b0, NO_ENTRY},
      '{CMD_COUNT, 7'd127,     1'b0, NO_ENTRY},
      '{CMD_COUNT, 7'd33,      1'b0, NO_ENTRY},
      '{CMD_COUNT, 7'd35,      1'b0, NO_ENTRY},
      '{CMD_FETCH, 7'd0,       1'b1, '{1'b1, 7'd1, 16'd1, 1'b0}},
      '{CMD_FETCH, 7'd85,      1'b0, NO_ENTRY},
      '{CMD_COUNT, 7'd2,       1'b0, NO_ENTRY},
      '{CMD_FETCH, 7'd42,      1'b0, NO_ENTRY},
      '{CMD_FETCH, 7'd0,       1'b1, '{1'b1, 7'd127, 16'd2, 1'b1}},
      '{CMD_FETCH, 7'd0,       1'b1, NO_ENTRY},
      '{CMD_COUNT, 7'd127,     1'b0, NO_ENTRY},
      '{CMD_FETCH, 7'd0,       1'b1, '{1'b1, 7'd127, 16'd1, 1'b1}},
      '{CMD_COUNT, 7'd64,      1'b0, NO_ENTRY},
      '{CMD_COUNT, 7'd64,      1'b0, NO_ENTRY},
      '{CMD_FETCH, 7'd0,       1'b0, NO_ENTRY},
      '{CMD_COUNT, 7'd1,       1'b0, NO_ENTRY},
      '{CMD_COUNT, 7'd2,       1'b0, NO_ENTRY},
      '{CMD_FETCH, 7'd0,       1'b0, NO_ENTRY},
      '{CMD_COUNT, 7'd1,       1'b0, NO_ENTRY},
      '{CMD_FETCH, 7'd0,       1'b0, NO_ENTRY},
      '{CMD_FETCH, 7'd0,       1'b1, NO_ENTRY}
   };

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_op;
   logic [SYMBOL_BITS-1:0] req_symbol;
   logic                   rsp_strobe;
   logic                   rsp_found;
   logic [SYMBOL_BITS-1:0] rsp_char_code;
   logic [OCC_BITS-1:0]    rsp_occurrences;
   logic                   rsp_last_entry;

   int unsigned       tally [ALPHABET];
   int                scan_pos;
   listing_entry_type due_entries [$];
   listing_entry_type oldest;
   int                mismatches;
   int                cycle_count;
   int                placed;

   character_frequency_count_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_symbol      (req_symbol),
      .rsp_strobe      (rsp_strobe),
      .rsp_found       (rsp_found),
      .rsp_char_code   (rsp_char_code),
      .rsp_occurrences (rsp_occurrences),
      .rsp_last_entry  (rsp_last_entry)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic listing_entry_type tally_step(cmd_type cmd,
                                                    logic [SYMBOL_BITS-1:0] sym);
      listing_entry_type r;
      int                hit;
      bit                more;
      r    = '0;
      hit  = -1;
      more = 1'b0;
      if (cmd == CMD_COUNT) begin
         if (sym != 0 && sym != QUOTE_CODE && tally[sym] < TALLY_MAX)
            tally[sym] = tally[sym] + 1;
         return r;
      end
      for (int i = scan_pos; i < ALPHABET; i++) begin
         if (tally[i] != 0) begin
            if (hit < 0)
               hit = i;
            else begin
               more = 1'b1;
               break;
            end
         end
      end
      if (hit < 0) begin
         scan_pos = 0;
         return r;
      end
      r.found = 1'b1;
      r.code  = hit[SYMBOL_BITS-1:0];
      r.occ   = tally[hit][OCC_BITS-1:0];
      r.last  = ~more;
      if (more)
         scan_pos = hit + 1;
      else begin
         foreach (tally[i]) tally[i] = 0;
         scan_pos = 0;
      end
      return r;
   endfunction

   function automatic int draw_gap(bit quiet);
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic hold_off(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic issue(input cmd_type cmd, input logic [SYMBOL_BITS-1:0] sym,
                        input bit quiet, input bit typed, input listing_entry_type want,
                        output listing_entry_type pred);
      @(negedge clock);
      start      <= 1'b1;
      req_op     <= cmd;
      req_symbol <= sym;
      @(posedge clock);
      while (busy) @(posedge clock);
      pred = tally_step(cmd, sym);
      if (cmd == CMD_FETCH)
         due_entries.push_back(typed ? want : pred);
      if (cmd == CMD_FETCH || (sym != 0 && sym != QUOTE_CODE))
         placed++;
      hold_off(draw_gap(quiet));
   endtask

   task automatic drain();
      hold_off(1);
      while (due_entries.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (due_entries.size() == 0) begin
            $error("result with no transaction pending: char_code %0d", rsp_char_code);
            mismatches++;
         end else begin
            oldest = due_entries.pop_front();
            if (rsp_found !== oldest.found) begin
               $error("found mismatch: expected %0d, actual %0d", oldest.found, rsp_found);
               mismatches++;
            end
            if (rsp_char_code !== oldest.code) begin
               $error("char_code mismatch: expected %0d, actual %0d",
                      oldest.code, rsp_char_code);
               mismatches++;
            end
            if (rsp_occurrences !== oldest.occ) begin
               $error("occurrences mismatch: expected %0d, actual %0d",
                      oldest.occ, rsp_occurrences);
               mismatches++;
            end
            if (rsp_last_entry !== oldest.last) begin
               $error("last_entry mismatch: expected %0d, actual %0d",
                      oldest.last, rsp_last_entry);
               mismatches++;
            end
         end
      end
   end

   initial begin
      listing_entry_type      pred;
      int                     kind;
      int                     n;
      int                     pool_base;
      bit                     quiet;
      bit                     done;
      logic [SYMBOL_BITS-1:0] sym;

      reset       = 1'b1;
      start       = 1'b0;
      req_op      = CMD_COUNT;
      req_symbol  = '0;
      mismatches  = 0;
      cycle_count = 0;
      placed      = 0;
      scan_pos    = 0;
      foreach (tally[i]) tally[i] = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (SCRIPT[i])
         issue(SCRIPT[i].cmd, SCRIPT[i].sym, 1'b0, SCRIPT[i].typed, SCRIPT[i].want, pred);
      drain();

      placed = 0;
      while (placed < RANDOM_ITEMS) begin
         kind  = $urandom_range(0, 9);
         quiet = ($urandom_range(0, 3) == 0);
         if (kind <= 6 || kind == 8) begin
            n         = $urandom_range(1, 40);
            pool_base = $urandom_range(1, 120);
            repeat (n) begin
               if ($urandom_range(0, 1))
                  sym = SYMBOL_BITS'(pool_base + $urandom_range(0, 7));
               else
                  sym = SYMBOL_BITS'($urandom_range(0, 127));
               issue(CMD_COUNT, sym, quiet, 1'b0, NO_ENTRY, pred);
            end
            // full listing, or a listing broken off early
            n    = (kind == 8) ? $urandom_range(1, 3) : 200;
            done = 1'b0;
            while (!done && n > 0) begin
               if ($urandom_range(0, 7) == 0)
                  issue(CMD_COUNT, SYMBOL_BITS'($urandom_range(1, 127)), quiet, 1'b0,
                        NO_ENTRY, pred);
               issue(CMD_FETCH, SYMBOL_BITS'($urandom_range(0, 127)), quiet, 1'b0,
                     NO_ENTRY, pred);
               done = pred.last || !pred.found;
               n--;
            end
         end else if (kind == 7) begin
            repeat ($urandom_range(1, 10))
               issue(($urandom_range(0, 3) == 0) ? CMD_FETCH : CMD_COUNT,
                     SYMBOL_BITS'($urandom_range(0, 127)), quiet, 1'b0, NO_ENTRY, pred);
         end else begin
            drain();
         end
      end

      drain();
      repeat (ALPHABET + 20) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
src/cfc_pkg.sv
src/cfc_front.sv
src/cfc_back.sv
src/character_frequency_count_top.sv
tb/sv/character_frequency_count_top_tb.sv
